FILE: hw/rtl/dynamic_window_cluster_match_top_macros.svh
// assertion macros for the dynamic window cluster matcher
`ifndef DYNAMIC_WINDOW_CLUSTER_MATCH_TOP_MACROS_SVH
`define DYNAMIC_WINDOW_CLUSTER_MATCH_TOP_MACROS_SVH

// condition holds whenever out of reset
`define DCM_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define DCM_ASSERT_IMPLIES(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// next-cycle implication
`define DCM_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

FILE: hw/rtl/dcm_pkg.sv
// shared types, constants and rom builder for the cluster matcher
package dcm_pkg;

    localparam int E_W   = 20;
    localparam int ETA_W = 13;
    localparam int PHI_W = 13;
    localparam int SIDE_W = 2;
    localparam int NX_W  = 10;

    localparam int COSH_TABLE_DEPTH = 1024;
    localparam int ROM_AW  = $clog2(COSH_TABLE_DEPTH);
    localparam int ENTRY_W = 17;
    localparam int TAYLOR_TERMS = 40;

    localparam int ABS_W  = ETA_W;
    localparam int UP_W   = 14;
    localparam int DOWN_W = 15;
    localparam int WPHI_W = 15;
    localparam int DETA_W = 15;
    localparam int DPHI_S_W = 15;
    localparam int DPHI_W = 14;
    localparam int DETA30_W = 20;
    localparam int DPHI30_W = 19;

    localparam int WIN_BREAK   = 1500;
    localparam int UP_BASE30   = 3000;
    localparam int DOWN_BASE30 = -3000;
    localparam int WPHI_BASE30 = 21000;
    localparam int PI_MRAD     = 3142;
    localparam int TWO_PI_MRAD = 6283;

    localparam int PROD_W   = E_W + ENTRY_W;
    localparam int ET_FRAC  = 16;
    localparam int ET_ROUND = 1 << (ET_FRAC - 1);
    localparam logic [E_W-1:0] ET_MAX = {E_W{1'b1}};

    typedef logic [ENTRY_W-1:0] rom_word_t;
    typedef rom_word_t rom_t [COSH_TABLE_DEPTH];

    typedef struct packed {
        logic [ROM_AW-1:0]        seed_idx;
        logic [ROM_AW-1:0]        cand_idx;
        logic [E_W-1:0]           seed_energy;
        logic [E_W-1:0]           cand_energy;
        logic [UP_W-1:0]          up30;
        logic signed [DOWN_W-1:0] down30;
        logic [WPHI_W-1:0]        wphi30;
        logic signed [DETA_W-1:0] deta;
        logic [DPHI_W-1:0]        dphi;
        logic                     side_eq;
        logic                     is_self;
        logic [NX_W-1:0]          nxtals;
    } front_t;

    // shift and subtract long division, only for building the table
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned dvs);
        longint unsigned quo;
        longint unsigned rem;
        int b;
        quo = '0;
        rem = '0;
        for (b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= dvs)
            begin
                rem = rem - dvs;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // q16 reciprocal cosh table, evaluated at elaboration
    function automatic rom_t build_inv_cosh();
        rom_t rom;
        longint unsigned den;
        longint unsigned xq;
        longint unsigned sum;
        longint unsigned term;
        longint unsigned emx;
        longint unsigned ch;
        longint unsigned entry;
        int i;
        int n;
        den = 64'(1000 * COSH_TABLE_DEPTH);
        for (i = 0; i < COSH_TABLE_DEPTH; i++)
        begin
            xq = (64'(i) * 64'd4096) << 24;
            xq = udiv64(xq + (den >> 1), den);
            sum = 64'd1 << 24;
            term = sum;
            for (n = 1; n <= TAYLOR_TERMS; n++)
            begin
                term = udiv64(term * xq, 64'(n) << 24);
                sum = sum + term;
            end
            emx = udiv64((64'd1 << 48) + (sum >> 1), sum);
            ch = (sum + emx + 64'd1) >> 1;
            entry = udiv64((64'd1 << 40) + (ch >> 1), ch);
            rom[i] = ENTRY_W'(entry);
        end
        return rom;
    endfunction

endpackage

FILE: hw/rtl/dcm_front.sv
// first stage: rom indexes, window bounds and seed-to-candidate offsets
module dcm_front (
    input  logic                                clk,
    input  logic                                load,
    input  logic [dcm_pkg::E_W-1:0]             seed_energy,
    input  logic signed [dcm_pkg::ETA_W-1:0]    seed_rapidity,
    input  logic signed [dcm_pkg::PHI_W-1:0]    seed_azimuth,
    input  logic signed [dcm_pkg::SIDE_W-1:0]   seed_side,
    input  logic [dcm_pkg::E_W-1:0]             cand_energy,
    input  logic signed [dcm_pkg::ETA_W-1:0]    cand_eta,
    input  logic signed [dcm_pkg::PHI_W-1:0]    cand_phi,
    input  logic signed [dcm_pkg::SIDE_W-1:0]   cand_iz,
    input  logic [dcm_pkg::NX_W-1:0]            cand_nxtals,
    input  logic                                is_self,
    output dcm_pkg::front_t                     front
);
    import dcm_pkg::*;

    localparam int IDX_FULL_W = ABS_W + ROM_AW + 2;
    localparam int IDX_SHIFT  = 12;
    localparam int IDX_HALF   = 1 << (IDX_SHIFT - 1);

    function automatic logic [ABS_W-1:0] abs_eta(input logic signed [ETA_W-1:0] eta);
        logic signed [ETA_W:0] neg;
        neg = -((ETA_W + 1)'(eta));
        return eta[ETA_W-1] ? ABS_W'(unsigned'(neg)) : ABS_W'(unsigned'(eta));
    endfunction

    function automatic logic [ROM_AW-1:0] rom_index(input logic [ABS_W-1:0] a);
        logic [IDX_FULL_W-1:0] scaled;
        scaled = (IDX_FULL_W'(a) * IDX_FULL_W'(COSH_TABLE_DEPTH) + IDX_FULL_W'(IDX_HALF))
                 >> IDX_SHIFT;
        if (scaled > IDX_FULL_W'(COSH_TABLE_DEPTH - 1))
        begin
            return ROM_AW'(COSH_TABLE_DEPTH - 1);
        end
        return ROM_AW'(scaled);
    endfunction

    logic [ABS_W-1:0]           seed_abs;
    logic [ABS_W-1:0]           cand_abs;
    logic signed [DOWN_W-1:0]   two_a;
    logic signed [DETA_W-1:0]   deta_raw;
    logic signed [DPHI_S_W-1:0] dphi_raw;
    logic signed [DPHI_S_W-1:0] dphi_wrap;
    logic signed [DPHI_S_W-1:0] dphi_neg;
    front_t                     front_next;
    front_t                     front_reg;

    assign seed_abs = abs_eta(seed_rapidity);
    assign cand_abs = abs_eta(cand_eta);
    assign two_a    = signed'({1'b0, seed_abs, 1'b0});
    assign deta_raw = DETA_W'(cand_eta) - DETA_W'(seed_rapidity);
    assign dphi_raw = DPHI_S_W'(seed_azimuth) - DPHI_S_W'(cand_phi);
    assign dphi_neg = -dphi_wrap;

    // wrap phi difference once at pi
    always_comb
    begin
        dphi_wrap = dphi_raw;
        if (dphi_raw > DPHI_S_W'(PI_MRAD))
        begin
            dphi_wrap = dphi_raw - DPHI_S_W'(TWO_PI_MRAD);
        end
        else if (dphi_raw < DPHI_S_W'(-PI_MRAD))
        begin
            dphi_wrap = dphi_raw + DPHI_S_W'(TWO_PI_MRAD);
        end
    end

    always_comb
    begin
        front_next.seed_idx    = rom_index(seed_abs);
        front_next.cand_idx    = rom_index(cand_abs);
        front_next.seed_energy = seed_energy;
        front_next.cand_energy = cand_energy;
        front_next.up30        = UP_W'({seed_abs, 1'b0}) + UP_W'(UP_BASE30);
        front_next.down30      = (seed_abs <= ABS_W'(WIN_BREAK)) ? DOWN_W'(DOWN_BASE30) : -two_a;
        front_next.wphi30      = WPHI_W'(WPHI_BASE30) - WPHI_W'(seed_abs);
        // mirror for a negative seed
        front_next.deta        = seed_rapidity[ETA_W-1] ? -deta_raw : deta_raw;
        front_next.dphi        = dphi_wrap[DPHI_S_W-1] ? DPHI_W'(unsigned'(dphi_neg))
                                                       : DPHI_W'(unsigned'(dphi_wrap));
        front_next.side_eq     = (seed_side == cand_iz);
        front_next.is_self     = is_self;
        front_next.nxtals      = cand_nxtals;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            front_reg <= front_next;
        end
    end

    assign front = front_reg;

endmodule

FILE: hw/rtl/dcm_rom.sv
// reciprocal cosh rom with two registered read ports
module dcm_rom (
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [dcm_pkg::ROM_AW-1:0]    addr_a,
    input  logic [dcm_pkg::ROM_AW-1:0]    addr_b,
    output logic [dcm_pkg::ENTRY_W-1:0]   data_a,
    output logic [dcm_pkg::ENTRY_W-1:0]   data_b
);
    import dcm_pkg::*;

    localparam rom_t INV_COSH = build_inv_cosh();

    logic [ENTRY_W-1:0] data_a_reg;
    logic [ENTRY_W-1:0] data_b_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            data_a_reg <= INV_COSH[addr_a];
            data_b_reg <= INV_COSH[addr_b];
        end
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule

FILE: hw/rtl/dcm_et.sv
// energy times reciprocal cosh, then rounding and saturation to et
module dcm_et (
    input  logic                          clk,
    input  logic                          load_mul,
    input  logic                          load_out,
    input  logic [dcm_pkg::E_W-1:0]       energy,
    input  logic [dcm_pkg::ENTRY_W-1:0]   entry,
    output logic [dcm_pkg::E_W-1:0]       et
);
    import dcm_pkg::*;

    localparam int SUM_W = PROD_W + 1;
    localparam int SHR_W = SUM_W - ET_FRAC;

    logic [PROD_W-1:0] prod_reg;
    logic [SUM_W-1:0]  rounded;
    logic [SHR_W-1:0]  shifted;
    logic [E_W-1:0]    et_next;
    logic [E_W-1:0]    et_reg;

    assign rounded = SUM_W'(prod_reg) + SUM_W'(ET_ROUND);
    assign shifted = rounded[SUM_W-1:ET_FRAC];
    assign et_next = (shifted > SHR_W'(ET_MAX)) ? ET_MAX : E_W'(shifted);

    always_ff @(posedge clk)
    begin
        if (load_mul)
        begin
            prod_reg <= PROD_W'(energy) * PROD_W'(entry);
        end
        if (load_out)
        begin
            et_reg <= et_next;
        end
    end

    assign et = et_reg;

endmodule

FILE: hw/rtl/dynamic_window_cluster_match_top.sv
// top level of the dynamic window cluster matcher
// Takes one seed/candidate pair per transfer and returns one result per pair. Four register
// stages (front end, rom read with window test, multiply, round and output) sustain one pair
// per cycle while the output is not stalled; the two read ports of the reciprocal cosh rom
// serve seed and candidate in the same cycle. Each stage holds only while the next is full
// and cannot move, so bubbles close up during an output stall. The Et threshold is compared
// at the output, and cfg_we should only be used while no pair is in flight.
`include "dynamic_window_cluster_match_top_macros.svh"

module dynamic_window_cluster_match_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [dcm_pkg::E_W-1:0]             cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [dcm_pkg::E_W-1:0]             seed_energy,
    input  logic signed [dcm_pkg::ETA_W-1:0]    seed_rapidity,
    input  logic signed [dcm_pkg::PHI_W-1:0]    seed_azimuth,
    input  logic signed [dcm_pkg::SIDE_W-1:0]   seed_side,
    input  logic [dcm_pkg::E_W-1:0]             cand_energy,
    input  logic signed [dcm_pkg::ETA_W-1:0]    cand_eta,
    input  logic signed [dcm_pkg::PHI_W-1:0]    cand_phi,
    input  logic signed [dcm_pkg::SIDE_W-1:0]   cand_iz,
    input  logic [dcm_pkg::NX_W-1:0]            cand_nxtals,
    input  logic                                is_self,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                seed_accepted,
    output logic [dcm_pkg::E_W-1:0]             seed_et,
    output logic                                member,
    output logic [dcm_pkg::E_W-1:0]             cand_et,
    output logic [dcm_pkg::NX_W-1:0]            member_nxtals
);
    import dcm_pkg::*;

    front_t                 front;
    logic [ENTRY_W-1:0]     seed_entry;
    logic [ENTRY_W-1:0]     cand_entry;

    logic [E_W-1:0]         thr_reg;
    logic                   v1_reg;
    logic                   v2_reg;
    logic                   v3_reg;
    logic                   v4_reg;
    logic                   rdy1;
    logic                   rdy2;
    logic                   rdy3;
    logic                   rdy4;

    logic signed [DETA30_W-1:0] deta_ext;
    logic signed [DETA30_W-1:0] deta30;
    logic [DPHI30_W-1:0]        dphi_ext;
    logic [DPHI30_W-1:0]        dphi30;
    logic                       in_win;
    logic                       member_next;

    logic                   member2_reg;
    logic [NX_W-1:0]        nx2_reg;
    logic [E_W-1:0]         seed_e2_reg;
    logic [E_W-1:0]         cand_e2_reg;
    logic                   member3_reg;
    logic [NX_W-1:0]        nx3_reg;
    logic                   member4_reg;
    logic [NX_W-1:0]        nx4_reg;

    // stage handshake, a stage loads when empty or when its successor moves
    assign rdy4 = !v4_reg || !out_stall;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign in_stall = !rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            thr_reg <= E_W'(1000);
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
        end
    end

    dcm_front u_front (
        .clk           (clk),
        .load          (rdy1),
        .seed_energy   (seed_energy),
        .seed_rapidity (seed_rapidity),
        .seed_azimuth  (seed_azimuth),
        .seed_side     (seed_side),
        .cand_energy   (cand_energy),
        .cand_eta      (cand_eta),
        .cand_phi      (cand_phi),
        .cand_iz       (cand_iz),
        .cand_nxtals   (cand_nxtals),
        .is_self       (is_self),
        .front         (front)
    );

    dcm_rom u_rom (
        .clk    (clk),
        .rd_en  (rdy2),
        .addr_a (front.seed_idx),
        .addr_b (front.cand_idx),
        .data_a (seed_entry),
        .data_b (cand_entry)
    );

    // window test, everything scaled by 30
    assign deta_ext = DETA30_W'(front.deta);
    assign deta30   = (deta_ext <<< 5) - (deta_ext <<< 1);
    assign dphi_ext = DPHI30_W'(front.dphi);
    assign dphi30   = (dphi_ext << 5) - (dphi_ext << 1);
    assign in_win   = front.side_eq
                   && (deta30 >= DETA30_W'(front.down30))
                   && (deta30 <= signed'(DETA30_W'(front.up30)))
                   && (dphi30 <= DPHI30_W'(front.wphi30));
    assign member_next = front.is_self || in_win;

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            member2_reg <= member_next;
            nx2_reg     <= front.nxtals;
            seed_e2_reg <= front.seed_energy;
            cand_e2_reg <= front.cand_energy;
        end
        if (rdy3)
        begin
            member3_reg <= member2_reg;
            nx3_reg     <= nx2_reg;
        end
        if (rdy4)
        begin
            member4_reg <= member3_reg;
            nx4_reg     <= member3_reg ? nx3_reg : '0;
        end
    end

    dcm_et u_seed_et (
        .clk      (clk),
        .load_mul (rdy3),
        .load_out (rdy4),
        .energy   (seed_e2_reg),
        .entry    (seed_entry),
        .et       (seed_et)
    );

    dcm_et u_cand_et (
        .clk      (clk),
        .load_mul (rdy3),
        .load_out (rdy4),
        .energy   (cand_e2_reg),
        .entry    (cand_entry),
        .et       (cand_et)
    );

    assign out_valid     = v4_reg;
    assign seed_accepted = (seed_et >= thr_reg);
    assign member        = member4_reg;
    assign member_nxtals = nx4_reg;

    `DCM_ASSERT_IMPLIES(a_nxtals_only_members, out_valid && (member_nxtals != '0), member, "crystal count on a non-member")
    `DCM_ASSERT_NEXT(a_stage_reaches_output, v3_reg && rdy4, out_valid, "result lost before the output register")
    `DCM_ASSERT_HOLDS(a_empty_pipe_accepts, (v1_reg || v2_reg || v3_reg || v4_reg) || !in_stall, "empty pipeline stalls input")

endmodule

FILE: verif/tb_dynamic_window_cluster_match_top.sv
// self-checking testbench for the dynamic window cluster matcher top level
`timescale 1ns / 100ps

module tb_dynamic_window_cluster_match_top;

    localparam int        ROM_DEPTH   = dcm_pkg::COSH_TABLE_DEPTH;
    localparam int        SERIES_LEN  = 40;
    localparam int        HALF_TURN   = 3142;
    localparam int        FULL_TURN   = 6283;
    localparam int        MAX_ENERGY  = 1048575;
    localparam int        RESET_ET_MIN = 1000;
    localparam int        QUIET_LIMIT = 2000;
    localparam int        DRAIN_CYCLES = 8;

    typedef logic [dcm_pkg::E_W-1:0]           energy_t;
    typedef logic signed [dcm_pkg::ETA_W-1:0]  eta_t;
    typedef logic signed [dcm_pkg::PHI_W-1:0]  phi_t;
    typedef logic signed [dcm_pkg::SIDE_W-1:0] side_t;
    typedef logic [dcm_pkg::NX_W-1:0]          nx_t;

    typedef struct {
        energy_t seed_energy;
        eta_t    seed_rapidity;
        phi_t    seed_azimuth;
        side_t   seed_side;
        energy_t cand_energy;
        eta_t    cand_eta;
        phi_t    cand_phi;
        side_t   cand_iz;
        nx_t     cand_nxtals;
        logic    is_self;
    } pair_t;

    typedef struct {
        logic    seed_accepted;
        energy_t seed_et;
        logic    member;
        energy_t cand_et;
        nx_t     member_nxtals;
    } match_t;

    logic    clk;
    logic    rst_n;
    logic    cfg_we;
    energy_t cfg_wdata;
    logic    in_valid;
    logic    in_stall;
    energy_t seed_energy;
    eta_t    seed_rapidity;
    phi_t    seed_azimuth;
    side_t   seed_side;
    energy_t cand_energy;
    eta_t    cand_eta;
    phi_t    cand_phi;
    side_t   cand_iz;
    nx_t     cand_nxtals;
    logic    is_self;
    logic    out_valid;
    logic    out_stall;
    logic    seed_accepted;
    energy_t seed_et;
    logic    member;
    energy_t cand_et;
    nx_t     member_nxtals;

    match_t  pending_matches[$];
    energy_t et_threshold;
    int      fail_count;
    int      quiet_cycles;
    int      hold_cycles;
    int      stall_left;
    bit      sender_gaps;
    bit      receiver_gaps;

    dynamic_window_cluster_match_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .seed_energy   (seed_energy),
        .seed_rapidity (seed_rapidity),
        .seed_azimuth  (seed_azimuth),
        .seed_side     (seed_side),
        .cand_energy   (cand_energy),
        .cand_eta      (cand_eta),
        .cand_phi      (cand_phi),
        .cand_iz       (cand_iz),
        .cand_nxtals   (cand_nxtals),
        .is_self       (is_self),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .seed_accepted (seed_accepted),
        .seed_et       (seed_et),
        .member        (member),
        .cand_et       (cand_et),
        .member_nxtals (member_nxtals)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // q16 reciprocal cosh at table slot idx
    function automatic longint unsigned inv_cosh_q16(longint unsigned idx);
        longint unsigned den;
        longint unsigned xq;
        longint unsigned expx;
        longint unsigned term;
        longint unsigned expnx;
        longint unsigned ch;
        den = 64'd1000 * 64'(ROM_DEPTH);
        xq = (idx * 64'd4096) << 24;
        xq = (xq + den / 64'd2) / den;
        expx = 64'd1 << 24;
        term = expx;
        for (int n = 1; n <= SERIES_LEN; n++)
        begin
            term = (term * xq) / (64'(n) << 24);
            expx = expx + term;
        end
        expnx = ((64'd1 << 48) + expx / 64'd2) / expx;
        ch = (expx + expnx + 64'd1) >> 1;
        return ((64'd1 << 40) + ch / 64'd2) / ch;
    endfunction

    function automatic energy_t transverse_energy(energy_t e, eta_t eta);
        longint          s;
        longint unsigned a;
        longint unsigned idx;
        longint unsigned et;
        s = eta;
        a = (s < 0) ? -s : s;
        idx = (a * 64'(ROM_DEPTH) + 64'd2048) >> 12;
        if (idx > 64'(ROM_DEPTH - 1))
            idx = 64'(ROM_DEPTH - 1);
        et = (64'(e) * inv_cosh_q16(idx) + 64'd32768) >> 16;
        if (et > 64'(MAX_ENERGY))
            et = 64'(MAX_ENERGY);
        return energy_t'(et);
    endfunction

    function automatic bit inside_seed_window(pair_t p);
        longint s_eta;
        longint a;
        longint up30;
        longint down30;
        longint wphi30;
        longint deta;
        longint dphi;
        if (p.seed_side != p.cand_iz)
            return 1'b0;
        s_eta = p.seed_rapidity;
        a = (s_eta < 0) ? -s_eta : s_eta;
        if (a <= 1500)
        begin
            up30 = 2 * a + 3000;
            down30 = -3000;
        end
        else
        begin
            up30 = 2 * (a - 1500) + 6000;
            down30 = -2 * (a - 1500) - 3000;
        end
        wphi30 = 21000 - a;
        deta = longint'(p.cand_eta) - s_eta;
        if (s_eta < 0)
            deta = -deta;
        dphi = longint'(p.seed_azimuth) - longint'(p.cand_phi);
        if (dphi > HALF_TURN)
            dphi = dphi - FULL_TURN;
        if (dphi < -HALF_TURN)
            dphi = dphi + FULL_TURN;
        if (dphi < 0)
            dphi = -dphi;
        return (30 * deta >= down30) && (30 * deta <= up30) && (30 * dphi <= wphi30);
    endfunction

    function automatic match_t compute_match(pair_t p, energy_t thr);
        match_t m;
        m.seed_et = transverse_energy(p.seed_energy, p.seed_rapidity);
        m.cand_et = transverse_energy(p.cand_energy, p.cand_eta);
        m.seed_accepted = (m.seed_et >= thr);
        m.member = p.is_self || inside_seed_window(p);
        m.member_nxtals = m.member ? p.cand_nxtals : '0;
        return m;
    endfunction

    function automatic pair_t make_pair(int s_en, int s_eta, int s_phi, int s_side,
                                        int c_en, int c_eta, int c_phi, int c_iz,
                                        int nx, int self_flag);
        pair_t p;
        p.seed_energy   = dcm_pkg::E_W'(s_en);
        p.seed_rapidity = dcm_pkg::ETA_W'(s_eta);
        p.seed_azimuth  = dcm_pkg::PHI_W'(s_phi);
        p.seed_side     = dcm_pkg::SIDE_W'(s_side);
        p.cand_energy   = dcm_pkg::E_W'(c_en);
        p.cand_eta      = dcm_pkg::ETA_W'(c_eta);
        p.cand_phi      = dcm_pkg::PHI_W'(c_phi);
        p.cand_iz       = dcm_pkg::SIDE_W'(c_iz);
        p.cand_nxtals   = dcm_pkg::NX_W'(nx);
        p.is_self       = self_flag[0];
        return p;
    endfunction

    function automatic int pick_energy();
        if ($urandom_range(0, 1) == 0)
            return $urandom_range(0, 5000);
        return $urandom_range(0, MAX_ENERGY);
    endfunction

    // mostly candidates near the seed window, some raw bit noise
    function automatic pair_t random_pair();
        int s_eta;
        int s_phi;
        int s_side;
        int c_iz;
        int c_eta;
        int c_phi;
        pair_t p;
        if ($urandom_range(0, 9) < 2)
        begin
            p.seed_energy   = dcm_pkg::E_W'($urandom);
            p.seed_rapidity = dcm_pkg::ETA_W'($urandom);
            p.seed_azimuth  = dcm_pkg::PHI_W'($urandom);
            p.seed_side     = dcm_pkg::SIDE_W'($urandom);
            p.cand_energy   = dcm_pkg::E_W'($urandom);
            p.cand_eta      = dcm_pkg::ETA_W'($urandom);
            p.cand_phi      = dcm_pkg::PHI_W'($urandom);
            p.cand_iz       = dcm_pkg::SIDE_W'($urandom);
            p.cand_nxtals   = dcm_pkg::NX_W'($urandom);
            p.is_self       = 1'($urandom_range(0, 1));
            return p;
        end
        if ($urandom_range(0, 9) == 0)
            s_eta = int'($urandom_range(0, 8191)) - 4096;
        else
            s_eta = int'($urandom_range(0, 6000)) - 3000;
        s_phi = int'($urandom_range(0, 2 * HALF_TURN)) - HALF_TURN;
        s_side = int'($urandom_range(0, 2)) - 1;
        c_iz = ($urandom_range(0, 4) != 0) ? s_side : int'($urandom_range(0, 2)) - 1;
        c_eta = s_eta + int'($urandom_range(0, 800)) - 400;
        c_phi = s_phi + int'($urandom_range(0, 1800)) - 900;
        if (c_phi > HALF_TURN)
            c_phi = c_phi - FULL_TURN;
        if (c_phi < -HALF_TURN)
            c_phi = c_phi + FULL_TURN;
        return make_pair(pick_energy(), s_eta, s_phi, s_side, pick_energy(), c_eta, c_phi,
                         c_iz, $urandom_range(0, 1023), int'($urandom_range(0, 7) == 0));
    endfunction

    task automatic send_pair(pair_t p);
        int gap;
        if (sender_gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        seed_energy   = p.seed_energy;
        seed_rapidity = p.seed_rapidity;
        seed_azimuth  = p.seed_azimuth;
        seed_side     = p.seed_side;
        cand_energy   = p.cand_energy;
        cand_eta      = p.cand_eta;
        cand_phi      = p.cand_phi;
        cand_iz       = p.cand_iz;
        cand_nxtals   = p.cand_nxtals;
        is_self       = p.is_self;
        in_valid      = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        pending_matches.insert(pending_matches.size(), compute_match(p, et_threshold));
    endtask

    task automatic send_random(int count);
        repeat (count) send_pair(random_pair());
    endtask

    task automatic wait_drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_threshold(energy_t value);
        wait_drain();
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        et_threshold = value;
    endtask

    task automatic test_directed();
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(MAX_ENERGY, 0, 0, 0, MAX_ENERGY, 100, 700, 0, 1023, 0));
        send_pair(make_pair(MAX_ENERGY, 0, 0, 0, MAX_ENERGY, 101, 0, 0, 1023, 0));
        send_pair(make_pair(5000, 0, 0, 0, 5000, -100, -700, 0, 7, 0));
        send_pair(make_pair(5000, 0, 0, 0, 5000, -101, 0, 0, 7, 0));
        send_pair(make_pair(5000, 0, 0, 0, 5000, 0, 701, 0, 7, 0));
        // phi wrap across pi
        send_pair(make_pair(20000, 500, 3100, 1, 20000, 520, -3100, 1, 55, 0));
        send_pair(make_pair(20000, 500, 3142, 1, 20000, 500, -3142, 1, 55, 0));
        send_pair(make_pair(30000, 800, 4095, -1, 30000, 800, -4096, -1, 300, 0));
        // slope break of the eta bounds
        send_pair(make_pair(40000, 1500, 0, 1, 40000, 1700, 0, 1, 12, 0));
        send_pair(make_pair(40000, 1500, 0, 1, 40000, 1701, 0, 1, 12, 0));
        send_pair(make_pair(40000, 1501, 0, 1, 40000, 1701, 0, 1, 12, 0));
        // mirrored window for negative seed eta
        send_pair(make_pair(50000, -2000, 100, -1, 50000, -2233, 100, -1, 40, 0));
        send_pair(make_pair(50000, -2000, 100, -1, 50000, -2234, 100, -1, 40, 0));
        send_pair(make_pair(50000, -2000, 100, -1, 50000, -1867, 100, -1, 40, 0));
        send_pair(make_pair(50000, -2000, 100, -1, 50000, -1866, 100, -1, 40, 0));
        // side mismatch, then the seed itself
        send_pair(make_pair(1000, 0, 0, 1, 1000, 0, 0, -1, 99, 0));
        send_pair(make_pair(1000, 0, 0, 1, 1000, 0, 0, -1, 99, 1));
        send_pair(make_pair(1000, 0, 0, -2, 1000, 0, 0, -2, 512, 0));
        send_pair(make_pair(1000, 0, 0, -2, 1000, 0, 0, 1, 512, 0));
        send_pair(make_pair(MAX_ENERGY, 4095, -3142, 0, MAX_ENERGY, -4096, 3142, 0, 1023, 1));
        send_pair(make_pair(MAX_ENERGY, -3000, 0, 0, MAX_ENERGY, 3000, 0, 0, 1023, 0));
        // rejected seed that is still a member
        send_pair(make_pair(999, 0, 0, 0, 999, 0, 0, 0, 3, 0));
    endtask

    task automatic test_threshold_sweep();
        energy_t levels[4];
        levels[0] = '0;
        levels[1] = energy_t'(MAX_ENERGY);
        levels[2] = energy_t'($urandom_range(1, 200000));
        levels[3] = energy_t'(RESET_ET_MIN);
        foreach (levels[k])
        begin
            write_threshold(levels[k]);
            send_pair(make_pair(int'(levels[k]), 0, 0, 0, MAX_ENERGY, 0, 0, 0, 1, 0));
            send_pair(make_pair(int'(levels[k]) - 1, 0, 0, 0, 0, 0, 0, 0, 1, 0));
            send_pair(make_pair(MAX_ENERGY, 0, 0, 0, 0, 0, 0, 0, 1, 0));
            send_random(40);
        end
    endtask

    task automatic test_random_traffic();
        for (int seg = 0; seg < 10; seg++)
        begin
            sender_gaps = 1'($urandom_range(0, 1));
            receiver_gaps = 1'($urandom_range(0, 1));
            send_random(90);
        end
        sender_gaps = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    task automatic test_output_backpressure();
        sender_gaps = 1'b0;
        hold_cycles = 150;
        send_random(60);
        sender_gaps = 1'b1;
    endtask

    task automatic test_drain_pause();
        send_random(30);
        wait_drain();
        send_random(30);
    endtask

    task automatic test_no_idle();
        sender_gaps = 1'b0;
        receiver_gaps = 1'b0;
        send_random(150);
    endtask

    initial
    begin
        out_stall = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall = 1'b1;
                hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                out_stall = 1'b1;
                stall_left--;
            end
            else if (receiver_gaps && $urandom_range(0, 4) == 0)
            begin
                out_stall = 1'b1;
                stall_left = $urandom_range(1, 3) - 1;
            end
            else
                out_stall = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        match_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_matches.size() == 0)
            begin
                $error("result transfer with no pair outstanding");
                fail_count++;
            end
            else
            begin
                want = pending_matches.pop_front();
                if (seed_accepted !== want.seed_accepted)
                begin
                    $error("seed_accepted: expected %0d, got %0d",
                           want.seed_accepted, seed_accepted);
                    fail_count++;
                end
                if (seed_et !== want.seed_et)
                begin
                    $error("seed_et: expected %0d, got %0d", want.seed_et, seed_et);
                    fail_count++;
                end
                if (member !== want.member)
                begin
                    $error("member: expected %0d, got %0d", want.member, member);
                    fail_count++;
                end
                if (cand_et !== want.cand_et)
                begin
                    $error("cand_et: expected %0d, got %0d", want.cand_et, cand_et);
                    fail_count++;
                end
                if (member_nxtals !== want.member_nxtals)
                begin
                    $error("member_nxtals: expected %0d, got %0d",
                           want.member_nxtals, member_nxtals);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        seed_energy = '0;
        seed_rapidity = '0;
        seed_azimuth = '0;
        seed_side = '0;
        cand_energy = '0;
        cand_eta = '0;
        cand_phi = '0;
        cand_iz = '0;
        cand_nxtals = '0;
        is_self = 1'b0;
        et_threshold = energy_t'(RESET_ET_MIN);
        fail_count = 0;
        hold_cycles = 0;
        sender_gaps = 1'b1;
        receiver_gaps = 1'b1;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_threshold_sweep();
        test_random_traffic();
        test_output_backpressure();
        test_drain_pause();
        test_no_idle();

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
